>>> rtl/h2r_pkg.sv
// Shared widths, constants and hue offset codes for the HSL to RGB converter.
`default_nettype none
package h2r_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int HUE_W      = FRAC_BITS;
  localparam int UNIT_W     = FRAC_BITS + 1;
  localparam int LEVEL_W    = 2 * FRAC_BITS + 1;
  localparam int POS_W      = FRAC_BITS + 3;
  localparam int PROD_W     = LEVEL_W + UNIT_W;
  localparam int CH_W       = 3 * FRAC_BITS + 1;
  localparam int PIX_W      = 8;
  localparam int IN_FIELD_W = HUE_W + 2 * UNIT_W;
  localparam int IN_TDATA_W = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((3 * PIX_W + 7) / 8) * 8;
  localparam int STAGES     = 5;

  localparam logic [UNIT_W-1:0]  UNIT_ONE  = UNIT_W'(1) << FRAC_BITS;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << (2 * FRAC_BITS);
  localparam logic [CH_W-1:0]    CH_ONE    = CH_W'(1) << (3 * FRAC_BITS);
  localparam logic [PIX_W-1:0]   PIX_MAX   = '1;

  typedef logic [1:0] third_t;

  localparam third_t THIRD_GREEN = 2'd0;
  localparam third_t THIRD_RED   = 2'd1;
  localparam third_t THIRD_BLUE  = 2'd2;

endpackage
`default_nettype wire

>>> rtl/h2r_hue_pos.sv
// Hue position to channel weight: the trapezoid of the two-level rule for one offset.
`default_nettype none
module h2r_hue_pos
  import h2r_pkg::*;
(
  input  wire logic [HUE_W-1:0]  hue,
  input  wire third_t            third,
  output logic      [UNIT_W-1:0] num
);

  localparam logic [POS_W-1:0] ONE_P  = POS_W'(1) << FRAC_BITS;
  localparam logic [POS_W-1:0] TWO_P  = POS_W'(2) << FRAC_BITS;
  localparam logic [POS_W-1:0] TURN_P = POS_W'(3) << FRAC_BITS;
  localparam logic [POS_W-1:0] FOUR_P = POS_W'(4) << FRAC_BITS;

  logic [POS_W-1:0] t_raw;
  logic [POS_W-1:0] t_w;
  logic [POS_W-1:0] t2;

  always_comb begin
    t_raw = (POS_W'(hue) << 1) + POS_W'(hue) + (POS_W'(third) << FRAC_BITS);
    t_w   = (t_raw >= TURN_P) ? (t_raw - TURN_P) : t_raw;
    t2    = t_w << 1;
    priority if (t2 < ONE_P) begin
      num = UNIT_W'(t2);
    end else if (t2 < TURN_P) begin
      num = UNIT_ONE;
    end else if (t_w < TWO_P) begin
      num = UNIT_W'(FOUR_P - t2);
    end else begin
      num = '0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/h2r_levels.sv
// Lower level and level span from saturation, lightness and their product.
`default_nettype none
module h2r_levels
  import h2r_pkg::*;
(
  input  wire logic [UNIT_W-1:0]  sat,
  input  wire logic [UNIT_W-1:0]  light,
  input  wire logic [LEVEL_W-1:0] sl,
  output logic      [LEVEL_W-1:0] lo,
  output logic      [LEVEL_W-1:0] diff
);

  localparam int WIDE_W = LEVEL_W + 1;

  logic [WIDE_W-1:0] hi_w;
  logic [WIDE_W-1:0] lo_w;

  always_comb begin
    if (light < (UNIT_ONE >> 1)) begin
      hi_w = (WIDE_W'(light) << FRAC_BITS) + WIDE_W'(sl);
    end else begin
      hi_w = ((WIDE_W'(light) + WIDE_W'(sat)) << FRAC_BITS) - WIDE_W'(sl);
    end
    lo_w = (WIDE_W'(light) << (FRAC_BITS + 1)) - hi_w;
    lo   = LEVEL_W'(lo_w);
    diff = LEVEL_W'(hi_w - lo_w);
  end

endmodule
`default_nettype wire

>>> rtl/h2r_scale.sv
// Scales one channel value to 8 bits, rounding halves up and clamping at full scale.
`default_nettype none
module h2r_scale
  import h2r_pkg::*;
(
  input  wire logic [CH_W-1:0]  c,
  output logic      [PIX_W-1:0] pix
);

  localparam int SC_W = CH_W + PIX_W;
  localparam int Q_W  = SC_W - 3 * FRAC_BITS;

  logic [SC_W-1:0] scaled;
  logic [Q_W-1:0]  q;

  always_comb begin
    scaled = (SC_W'(c) << PIX_W) - SC_W'(c) + (SC_W'(1) << (3 * FRAC_BITS - 1));
    q      = scaled[SC_W-1:3*FRAC_BITS];
    pix    = (q > Q_W'(PIX_MAX)) ? PIX_MAX : q[PIX_W-1:0];
  end

endmodule
`default_nettype wire

>>> rtl/hsl_to_rgb_converter.sv
// Top level of the pipelined HSL to RGB converter with stream input and output.
//
// The input channel takes one beat per pixel: hue, saturation and lightness in
// unsigned fixed point with twelve fraction bits. The output channel gives one
// beat per input beat with the 8-bit red, green and blue values, in order.
// The datapath has five register stages: input clamp with the saturation by
// lightness product and hue weights, level computation, the three level-span
// multipliers, the channel sum, and the final scale and round. An accepted beat
// moves through the stage registers in order, and out_tvalid rises when it
// reaches the final stage. One beat is taken in every cycle while the output
// side keeps taking beats.
// When the receiver stalls, the stages in front of the output close up any
// empty slots and keep accepting input; in_tready falls only when all five
// stages hold a beat and out_tready is low. Nothing is dropped or repeated.
// The synchronous reset empties the pipeline; payload registers are not reset.
// The block keeps no state between pixels.
`default_nettype none
module hsl_to_rgb_converter
  import h2r_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // Fields from bit 0: hue[11:0], saturation[24:12], lightness[37:25], zero pad.
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // Fields from bit 0: red[7:0], green[15:8], blue[23:16].
  output logic      [OUT_TDATA_W-1:0] out_tdata
);

  typedef struct packed {
    logic [UNIT_W-1:0]        sat;
    logic [UNIT_W-1:0]        light;
    logic [LEVEL_W-1:0]       sl;
    logic [2:0][UNIT_W-1:0]   num;
    logic                     szero;
    logic [PIX_W-1:0]         gray;
  } s1_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]       lo;
    logic [LEVEL_W-1:0]       diff;
    logic [2:0][UNIT_W-1:0]   num;
    logic                     szero;
    logic [PIX_W-1:0]         gray;
  } s2_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]       lo;
    logic [2:0][PROD_W-1:0]   prod;
    logic                     szero;
    logic [PIX_W-1:0]         gray;
  } s3_t;

  typedef struct packed {
    logic [2:0][CH_W-1:0]     c;
    logic                     szero;
    logic [PIX_W-1:0]         gray;
  } s4_t;

  typedef struct packed {
    logic [2:0][PIX_W-1:0]    pix;
  } s5_t;

  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;
  logic [STAGES-1:0] adv;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  s4_t s4_r, s4_nxt;
  s5_t s5_r, s5_nxt;

  logic [HUE_W-1:0]       hue_in;
  logic [UNIT_W-1:0]      sat_in;
  logic [UNIT_W-1:0]      light_in;
  logic [UNIT_W-1:0]      sat_c;
  logic [UNIT_W-1:0]      light_c;
  logic [2*UNIT_W-1:0]    sl_full;
  logic [UNIT_W+PIX_W-1:0] gray_w;
  logic [2:0][UNIT_W-1:0] num_w;
  logic [LEVEL_W-1:0]     lo_w;
  logic [LEVEL_W-1:0]     diff_w;
  logic [2:0][PIX_W-1:0]  pix_w;

  // Pipeline control: a stage loads when it is empty or its successor loads.
  always_comb begin
    adv[STAGES-1] = !vld_r[STAGES-1] || out_tready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
    vld_nxt[0] = adv[0] ? in_tvalid : vld_r[0];
    for (int i = 1; i < STAGES; i++) begin
      vld_nxt[i] = adv[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[STAGES-1];
  assign out_tdata  = OUT_TDATA_W'({s5_r.pix[2], s5_r.pix[1], s5_r.pix[0]});

  // Stage 1: clamp, saturation by lightness product, hue weights, gray level.
  assign hue_in   = in_tdata[HUE_W-1:0];
  assign sat_in   = in_tdata[HUE_W +: UNIT_W];
  assign light_in = in_tdata[HUE_W+UNIT_W +: UNIT_W];

  for (genvar ch = 0; ch < 3; ch++) begin : g_hue
    h2r_hue_pos u_hue_pos (
      .hue   (hue_in),
      .third ((ch == 0) ? THIRD_RED : ((ch == 1) ? THIRD_GREEN : THIRD_BLUE)),
      .num   (num_w[ch])
    );
  end

  always_comb begin
    sat_c   = (sat_in > UNIT_ONE) ? UNIT_ONE : sat_in;
    light_c = (light_in > UNIT_ONE) ? UNIT_ONE : light_in;
    sl_full = (2*UNIT_W)'(sat_c) * (2*UNIT_W)'(light_c);
    gray_w  = ((UNIT_W+PIX_W)'(light_c) << PIX_W) - (UNIT_W+PIX_W)'(light_c);
    s1_nxt.sat   = sat_c;
    s1_nxt.light = light_c;
    s1_nxt.sl    = LEVEL_W'(sl_full);
    s1_nxt.num   = num_w;
    s1_nxt.szero = (sat_c == '0);
    s1_nxt.gray  = gray_w[FRAC_BITS +: PIX_W];
  end

  // Stage 2: lower level and span.
  h2r_levels u_levels (
    .sat   (s1_r.sat),
    .light (s1_r.light),
    .sl    (s1_r.sl),
    .lo    (lo_w),
    .diff  (diff_w)
  );

  always_comb begin
    s2_nxt.lo    = lo_w;
    s2_nxt.diff  = diff_w;
    s2_nxt.num   = s1_r.num;
    s2_nxt.szero = s1_r.szero;
    s2_nxt.gray  = s1_r.gray;
  end

  // Stage 3: span times hue weight, one multiplier per channel.
  always_comb begin
    s3_nxt.lo    = s2_r.lo;
    s3_nxt.szero = s2_r.szero;
    s3_nxt.gray  = s2_r.gray;
    for (int ch = 0; ch < 3; ch++) begin
      s3_nxt.prod[ch] = PROD_W'(s2_r.diff) * PROD_W'(s2_r.num[ch]);
    end
  end

  // Stage 4: channel value as lower level plus weighted span.
  always_comb begin
    s4_nxt.szero = s3_r.szero;
    s4_nxt.gray  = s3_r.gray;
    for (int ch = 0; ch < 3; ch++) begin
      s4_nxt.c[ch] = CH_W'((PROD_W'(s3_r.lo) << FRAC_BITS) + s3_r.prod[ch]);
    end
  end

  // Stage 5: scale to 8 bits, or the truncated gray level at zero saturation.
  for (genvar ch = 0; ch < 3; ch++) begin : g_scale
    h2r_scale u_scale (
      .c   (s4_r.c[ch]),
      .pix (pix_w[ch])
    );
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      s5_nxt.pix[ch] = s4_r.szero ? s4_r.gray : pix_w[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_r <= s1_nxt;
    end
    if (adv[1]) begin
      s2_r <= s2_nxt;
    end
    if (adv[2]) begin
      s3_r <= s3_nxt;
    end
    if (adv[3]) begin
      s4_r <= s4_nxt;
    end
    if (adv[4]) begin
      s5_r <= s5_nxt;
    end
  end

  a_ready_only_on_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input back-pressured while the pipeline could still advance");

  a_levels_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] |-> ((LEVEL_W+1)'(s2_r.lo) + (LEVEL_W+1)'(s2_r.diff)
                  <= (LEVEL_W+1)'(LEVEL_ONE)))
    else $error("upper level exceeds full scale");

  a_channels_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> (s4_r.c[0] <= CH_ONE && s4_r.c[1] <= CH_ONE && s4_r.c[2] <= CH_ONE))
    else $error("channel value exceeds full scale");

endmodule
`default_nettype wire
